// ===== sv/chp_pkg.sv =====
// Shared constants and types for the convex hull perimeter block.
// Used by convex_hull_perimeter and chp_isqrt; depends on nothing.
package chp_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CW         = $clog2(MAX_POINTS + 1);
  localparam int DW         = COORD_BITS + 1;       // coordinate difference
  localparam int PW         = 2 * DW;               // product of two differences
  localparam int D2W        = 2 * COORD_BITS + 2;   // dx*dx + dy*dy
  localparam int RADW       = D2W + 32;             // radicand, 16 fraction bits in root
  localparam int ROOTW      = RADW / 2;
  localparam int REMW       = ROOTW + 4;
  localparam int SUMW       = 48;
  localparam int PERIMW     = 34;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } point_t;

endpackage

// ===== sv/chp_isqrt.sv =====
// Bit-serial integer square root of (d2 << 32), one result bit per cycle.
// Depends on chp_pkg.
module chp_isqrt import chp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [D2W-1:0]   d2_i,
  output logic             done_o,
  output logic [ROOTW-1:0] root_o
);

  logic [RADW-1:0]  rad_q;
  logic [REMW-1:0]  rem_q;
  logic [ROOTW-1:0] root_q;
  logic [$clog2(ROOTW+1)-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [REMW-1:0]  rem_n, trial;

  assign rem_n  = {rem_q[REMW-3:0], rad_q[RADW-1 -: 2]};
  assign trial  = {{(REMW-ROOTW-2){1'b0}}, root_q, 2'b01};
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rad_q  <= {d2_i, 32'd0};
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= ($clog2(ROOTW+1))'(ROOTW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rad_q <= {rad_q[RADW-3:0], 2'b00};
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[ROOTW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[ROOTW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/convex_hull_perimeter.sv =====
// Convex hull perimeter: points stream in, the last one flagged, and one
// perimeter result follows. Depends on chp_pkg and chp_isqrt.
//
// Each point is insertion-sorted into the point memory on arrival (one read
// and one write port); the block is not ready meanwhile. After the last
// point the sequencer scans the end columns and wraps the upper and lower
// chains: every candidate takes a memory read plus the two products of one
// cross product on the one shared 17x17 multiplier, and every hull edge a
// bit-serial square root. Points beyond 1024 are dropped and reported in
// tuser. The perimeter is unsigned with 16 fraction bits, saturated to 34 bits.
module convex_hull_perimeter import chp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pos_x [15:0], pos_y [31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // perimeter [33:0], zero [39:34]
  output logic        m_axis_tuser    // dropped
);

  typedef enum logic [4:0] {
    S_IDLE, S_WAIT, S_INS_CMP, S_INS_PUT, S_LOAD_DONE, S_CSTART, S_X0, S_LL,
    S_RR, S_RRU, S_TB, S_TJ, S_M1, S_M2, S_CMP, S_SQ1, S_SQ2, S_SQRT, S_RES
  } state_e;

  state_e state_q, ret_q;

  point_t mem [MAX_POINTS];
  point_t rd_q, wd_q, p_q;
  logic [AW-1:0] addr_q, wa_q;
  logic we_q;

  logic [CW-1:0] cnt_q, k_q, i_q, ll_q, j_q, b_q, best_q;
  logic ovf_q, last_q, upper_q;
  logic signed [COORD_BITS-1:0] x0_q, y0_q, ytl_q, xl_q, yl_q, ybr_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q, bx_q, by_q, candx_q, candy_q;
  logic signed [DW-1:0] bdx_q, bdy_q, cdx_q, cdy_q, rdx, rdy;
  logic signed [PW-1:0] lhs_q, rhs_q, mp;
  logic signed [DW-1:0] ma, mb;
  logic [PW-1:0] sqx_q;
  logic [SUMW-1:0] sum_q;
  logic sq_start_q;
  logic sq_done;
  logic [ROOTW-1:0] sq_root;
  logic [D2W-1:0] d2;
  logic out_valid_q, dropped_q;
  logic [PERIMW-1:0] perim_q;
  point_t s_pt;
  logic take;

  always_ff @(posedge clk_i) begin
    if (we_q) mem[wa_q] <= wd_q;
    rd_q <= mem[addr_q];
  end

  assign s_pt = point_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == S_IDLE);
  assign take = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(40-PERIMW){1'b0}}, perim_q};
  assign m_axis_tuser  = dropped_q;

  assign rdx = DW'(rd_q.x) - DW'(cx_q);
  assign rdy = DW'(rd_q.y) - DW'(cy_q);

  // shared multiplier
  always_comb begin
    unique case (state_q)
      S_M1:    begin ma = cdy_q; mb = bdx_q; end
      S_M2:    begin ma = bdy_q; mb = cdx_q; end
      S_SQ1:   begin ma = bdx_q; mb = bdx_q; end
      S_SQ2:   begin ma = bdy_q; mb = bdy_q; end
      default: begin ma = '0;    mb = '0;    end
    endcase
  end
  assign mp = ma * mb;
  assign d2 = D2W'(sqx_q);

  chp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start_q),
    .d2_i    (d2),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      we_q        <= 1'b0;
      sq_start_q  <= 1'b0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
    end else begin
      we_q       <= 1'b0;
      sq_start_q <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && state_q != S_RES) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            p_q    <= s_pt;
            last_q <= s_axis_tlast;
            if (cnt_q == CW'(MAX_POINTS)) begin
              ovf_q   <= 1'b1;
              state_q <= s_axis_tlast ? S_CSTART : S_IDLE;
            end else if (cnt_q == 0) begin
              we_q <= 1'b1; wa_q <= '0; wd_q <= s_pt;
              state_q <= S_LOAD_DONE;
            end else begin
              k_q    <= cnt_q;
              addr_q <= AW'(cnt_q - 1'b1);
              ret_q  <= S_INS_CMP;
              state_q <= S_WAIT;
            end
          end
        end
        S_WAIT: state_q <= ret_q;
        S_INS_CMP: begin
          if (rd_q.x > p_q.x || (rd_q.x == p_q.x && rd_q.y > p_q.y)) begin
            // shift the larger point up one slot
            we_q <= 1'b1; wa_q <= AW'(k_q); wd_q <= rd_q;
            k_q  <= k_q - 1'b1;
            if (k_q == 1) begin
              state_q <= S_INS_PUT;
            end else begin
              addr_q  <= AW'(k_q - 2'd2);
              state_q <= S_WAIT;
            end
          end else begin
            we_q <= 1'b1; wa_q <= AW'(k_q); wd_q <= p_q;
            state_q <= S_LOAD_DONE;
          end
        end
        S_INS_PUT: begin
          we_q <= 1'b1; wa_q <= AW'(k_q); wd_q <= p_q;
          state_q <= S_LOAD_DONE;
        end
        S_LOAD_DONE: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= last_q ? S_CSTART : S_IDLE;
        end
        S_CSTART: begin
          sum_q <= '0;
          if (cnt_q == 0) begin
            state_q <= S_RES;
          end else begin
            addr_q <= '0; ret_q <= S_X0; state_q <= S_WAIT;
          end
        end
        S_X0: begin
          x0_q <= rd_q.x; y0_q <= rd_q.y; ytl_q <= rd_q.y;
          if (cnt_q == 1) begin
            state_q <= S_RES;
          end else begin
            i_q <= CW'(1); addr_q <= AW'(1); ret_q <= S_LL; state_q <= S_WAIT;
          end
        end
        S_LL: begin
          if (rd_q.x == x0_q) begin
            ytl_q <= rd_q.y;
            if (i_q + 1'b1 == cnt_q) begin
              // single column: twice the y span
              sum_q <= SUMW'(DW'(rd_q.y) - DW'(y0_q)) << 17;
              state_q <= S_RES;
            end else begin
              i_q <= i_q + 1'b1; addr_q <= AW'(i_q + 1'b1); state_q <= S_WAIT;
            end
          end else begin
            ll_q <= i_q;
            addr_q <= AW'(cnt_q - 1'b1); ret_q <= S_RR; state_q <= S_WAIT;
          end
        end
        S_RR: begin
          xl_q <= rd_q.x; yl_q <= rd_q.y; ybr_q <= rd_q.y;
          j_q <= cnt_q - 2'd2;
          addr_q <= AW'(cnt_q - 2'd2); ret_q <= S_RRU; state_q <= S_WAIT;
        end
        S_RRU: begin
          if (rd_q.x == xl_q) begin
            ybr_q <= rd_q.y;
            j_q <= j_q - 1'b1; addr_q <= AW'(j_q - 1'b1); state_q <= S_WAIT;
          end else begin
            sum_q <= (SUMW'(DW'(ytl_q) - DW'(y0_q)) << 16)
                   + (SUMW'(DW'(yl_q) - DW'(ybr_q)) << 16);
            upper_q <= 1'b1;
            cx_q <= x0_q; cy_q <= ytl_q; b_q <= ll_q;
            addr_q <= AW'(ll_q); ret_q <= S_TB; state_q <= S_WAIT;
          end
        end
        S_TB: begin
          if (rd_q.x == cx_q) begin
            // skip the rest of the current column
            b_q <= b_q + 1'b1; addr_q <= AW'(b_q + 1'b1); state_q <= S_WAIT;
          end else begin
            bdx_q <= rdx; bdy_q <= rdy; best_q <= b_q;
            bx_q <= rd_q.x; by_q <= rd_q.y;
            if (b_q + 1'b1 < cnt_q) begin
              j_q <= b_q + 1'b1; addr_q <= AW'(b_q + 1'b1);
              ret_q <= S_TJ; state_q <= S_WAIT;
            end else begin
              state_q <= S_SQ1;
            end
          end
        end
        S_TJ: begin
          cdx_q <= rdx; cdy_q <= rdy; candx_q <= rd_q.x; candy_q <= rd_q.y;
          state_q <= S_M1;
        end
        S_M1: begin lhs_q <= mp; state_q <= S_M2; end
        S_M2: begin rhs_q <= mp; state_q <= S_CMP; end
        S_CMP: begin
          // ties keep the farther point
          if (upper_q ? (lhs_q >= rhs_q) : (lhs_q <= rhs_q)) begin
            best_q <= j_q; bdx_q <= cdx_q; bdy_q <= cdy_q;
            bx_q <= candx_q; by_q <= candy_q;
          end
          if (j_q + 1'b1 < cnt_q) begin
            j_q <= j_q + 1'b1; addr_q <= AW'(j_q + 1'b1); state_q <= S_WAIT;
          end else begin
            state_q <= S_SQ1;
          end
        end
        S_SQ1: begin sqx_q <= $unsigned(mp); state_q <= S_SQ2; end
        S_SQ2: begin
          // hold dx*dx + dy*dy for the root unit
          sqx_q      <= sqx_q + $unsigned(mp);
          sq_start_q <= 1'b1;
          state_q    <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            sum_q <= sum_q + SUMW'(sq_root);
            cx_q <= bx_q; cy_q <= by_q;
            if (bx_q == xl_q || best_q + 1'b1 >= cnt_q) begin
              if (upper_q) begin
                upper_q <= 1'b0;
                cx_q <= x0_q; cy_q <= y0_q; b_q <= ll_q;
                addr_q <= AW'(ll_q); ret_q <= S_TB; state_q <= S_WAIT;
              end else begin
                state_q <= S_RES;
              end
            end else begin
              b_q <= best_q + 1'b1; addr_q <= AW'(best_q + 1'b1);
              ret_q <= S_TB; state_q <= S_WAIT;
            end
          end
        end
        S_RES: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            perim_q   <= (sum_q > SUMW'({PERIMW{1'b1}})) ? {PERIMW{1'b1}}
                                                         : sum_q[PERIMW-1:0];
            dropped_q <= ovf_q;
            cnt_q     <= '0;
            ovf_q     <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
